FILE: rtl/pcoc_pkg.sv
// Shared types, codes and constants for the phase current offset calibration block.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package pcoc_pkg;

    localparam int SAMPLES_LOG2_DEF = 10;
    localparam int ADC_BITS_DEF     = 12;
    localparam int NUM_PHASES       = 3;

    localparam int OPC_W  = 2;
    localparam int CUR_W  = 21;
    localparam int GAIN_W = 16;
    localparam int MID_W  = 12;
    localparam int WIN_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd256;
    localparam logic [MID_W-1:0]  MIDPOINT_RESET = 12'd2048;
    localparam logic [WIN_W-1:0]  WINDOW_RESET   = 12'd75;

    localparam logic signed [39:0] CUR_MAX = 40'sd1048575;
    localparam logic signed [39:0] CUR_MIN = -40'sd1048576;

    typedef enum logic [OPC_W-1:0] {
        OPC_RESTART = 2'd0,
        OPC_CAL     = 2'd1,
        OPC_CONVERT = 2'd2,
        OPC_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN     = 2'd0,
        CFG_MIDPOINT = 2'd1,
        CFG_WINDOW   = 2'd2,
        CFG_UNUSED   = 2'd3
    } t_cfg_index;

    // Per-request commands from the top level to each phase lane.
    typedef struct packed {
        logic load;     // request accepted: capture the scaled product
        logic acc;      // calibration sample
        logic fin;      // calibration sample that completes the run
        logic clr;      // restart calibration
    } t_lane_cmd;

    // What travels with a request from the first stage to the output stage.
    typedef struct packed {
        logic conv;
        logic done;
    } t_stage_ctrl;

endpackage

FILE: rtl/pcoc_req_if.sv
// Input request channel: opcode plus one ADC sample per phase.
// Depends on pcoc_pkg for the opcode width.
interface pcoc_req_if #(
    parameter int ADC_BITS = pcoc_pkg::ADC_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [pcoc_pkg::OPC_W-1:0]   opcode;
    logic [ADC_BITS-1:0]          sample_a;
    logic [ADC_BITS-1:0]          sample_b;
    logic [ADC_BITS-1:0]          sample_c;

    modport source (output valid, opcode, sample_a, sample_b, sample_c, input ready);
    modport sink   (input valid, opcode, sample_a, sample_b, sample_c, output ready);
endinterface

FILE: rtl/pcoc_rsp_if.sv
// Result channel: scaled phase currents and calibration status.
// Depends on pcoc_pkg for the current width.
interface pcoc_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [pcoc_pkg::CUR_W-1:0] current_a;
    logic signed [pcoc_pkg::CUR_W-1:0] current_b;
    logic signed [pcoc_pkg::CUR_W-1:0] current_c;
    logic                              cal_done;
    logic                              cal_fault;

    modport source (output valid, current_a, current_b, current_c, cal_done, cal_fault,
                    input ready);
    modport sink   (input valid, current_a, current_b, current_c, cal_done, cal_fault,
                    output ready);
endinterface

FILE: rtl/pcoc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on pcoc_pkg for the index and data widths.
interface pcoc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pcoc_pkg::CFG_IDX_W-1:0]    index;
    logic [pcoc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/pcoc_lane.sv
// One phase lane: calibration accumulator, stored offset, gain multiply and saturation.
// Depends on pcoc_pkg for the command struct and the output range.
module pcoc_lane #(
    parameter int SAMPLES_LOG2 = pcoc_pkg::SAMPLES_LOG2_DEF,
    parameter int ADC_BITS     = pcoc_pkg::ADC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcoc_pkg::t_lane_cmd               i_cmd,
    input  logic [ADC_BITS-1:0]               i_sample,
    input  logic [pcoc_pkg::GAIN_W-1:0]       i_gain,
    input  logic [pcoc_pkg::MID_W-1:0]        i_midpoint,
    input  logic [pcoc_pkg::WIN_W-1:0]        i_window,
    output logic signed [pcoc_pkg::CUR_W-1:0] o_current,
    output logic                              o_out_window
);
    localparam int SUM_W  = ADC_BITS + SAMPLES_LOG2;
    localparam int DIFF_W = ADC_BITS + 1;
    localparam int PROD_W = DIFF_W + pcoc_pkg::GAIN_W + 1;
    localparam int CMP_W  = ((ADC_BITS > 14) ? ADC_BITS : 14) + 2;
    localparam logic [ADC_BITS-1:0] OFFSET_RESET = ADC_BITS'(1) << (ADC_BITS - 1);

    logic [SUM_W-1:0]         r_sum, n_sum;
    logic [ADC_BITS-1:0]      r_offset, n_offset;
    logic signed [PROD_W-1:0] r_prod;

    logic [SUM_W-1:0]         sum_plus;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [39:0]       q_ext;
    logic signed [CMP_W-1:0]  off_s, hi_s, lo_s;

    assign sum_plus = r_sum + SUM_W'(i_sample);

    always_comb begin
        n_sum    = r_sum;
        n_offset = r_offset;
        if (i_cmd.clr) begin
            n_sum = '0;
        end else if (i_cmd.acc) begin
            if (i_cmd.fin) begin
                n_offset = sum_plus[SUM_W-1:SAMPLES_LOG2];
                n_sum    = '0;
            end else begin
                n_sum = sum_plus;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_offset <= OFFSET_RESET;
        end else begin
            r_sum    <= n_sum;
            r_offset <= n_offset;
        end
    end

    // Offset-corrected sample times the unsigned gain, registered before the shift.
    assign diff = $signed({1'b0, i_sample}) - $signed({1'b0, r_offset});
    assign prod = PROD_W'(diff) * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prod <= prod;
        end
    end

    // Arithmetic shift gives the floor of the Q8.8 product, then clamp to 21 bits.
    assign prod_sh = r_prod >>> 8;
    assign q_ext   = 40'(prod_sh);

    always_comb begin
        if (q_ext > pcoc_pkg::CUR_MAX) begin
            o_current = pcoc_pkg::CUR_MAX[pcoc_pkg::CUR_W-1:0];
        end else if (q_ext < pcoc_pkg::CUR_MIN) begin
            o_current = pcoc_pkg::CUR_MIN[pcoc_pkg::CUR_W-1:0];
        end else begin
            o_current = q_ext[pcoc_pkg::CUR_W-1:0];
        end
    end

    assign off_s = $signed(CMP_W'(r_offset));
    assign hi_s  = $signed(CMP_W'(i_midpoint)) + $signed(CMP_W'(i_window));
    assign lo_s  = $signed(CMP_W'(i_midpoint)) - $signed(CMP_W'(i_window));
    assign o_out_window = (off_s > hi_s) || (off_s < lo_s);

endmodule

FILE: rtl/pcoc_merge.sv
// Output stage: combines the three lanes into one result and holds it until taken.
// Depends on pcoc_pkg for the stage control struct and widths.
module pcoc_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s1_valid,
    input  pcoc_pkg::t_stage_ctrl               i_ctrl,
    input  logic signed [pcoc_pkg::CUR_W-1:0]   i_current [pcoc_pkg::NUM_PHASES],
    input  logic [pcoc_pkg::NUM_PHASES-1:0]     i_out_window,
    output logic                                o_advance,
    pcoc_rsp_if.source                          o_rsp
);
    logic                              r_valid;
    logic signed [pcoc_pkg::CUR_W-1:0] r_current [pcoc_pkg::NUM_PHASES];
    logic                              r_done;
    logic                              r_fault;

    assign o_advance = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            for (int p = 0; p < pcoc_pkg::NUM_PHASES; p++) begin
                r_current[p] <= i_ctrl.conv ? i_current[p] : '0;
            end
            r_done  <= i_ctrl.done;
            r_fault <= i_ctrl.done && (|i_out_window);
        end
    end

    assign o_rsp.valid     = r_valid;
    assign o_rsp.current_a = r_current[0];
    assign o_rsp.current_b = r_current[1];
    assign o_rsp.current_c = r_current[2];
    assign o_rsp.cal_done  = r_done;
    assign o_rsp.cal_fault = r_fault;

endmodule

FILE: rtl/phase_current_offset_calibrate_top.sv
// Top level of the three-phase current-sense offset calibration block.
// Depends on pcoc_pkg, the three channel interfaces, pcoc_lane and pcoc_merge.
//
//  channel  | modport | carries
//  ---------+---------+-----------------------------------------------
//  i_req    | sink    | opcode, sample_a, sample_b, sample_c
//  o_rsp    | source  | current_a/b/c, cal_done, cal_fault
//  i_cfg    | sink    | index (gain, midpoint, window), data
//
// One request is accepted per cycle unless o_rsp stalls with both stages full; each result
// reaches o_rsp through two stages: the lanes' gain multiply, then the output register.
// A stall on o_rsp holds both stages; i_req.ready drops only when both are full.
// Reset restores the register defaults, clears the sums and count, and sets offsets to midscale.
module phase_current_offset_calibrate_top #(
    parameter int SAMPLES_LOG2 = pcoc_pkg::SAMPLES_LOG2_DEF,
    parameter int ADC_BITS     = pcoc_pkg::ADC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcoc_req_if.sink   i_req,
    pcoc_rsp_if.source o_rsp,
    pcoc_cfg_if.sink   i_cfg
);
    logic [pcoc_pkg::GAIN_W-1:0] r_gain;
    logic [pcoc_pkg::MID_W-1:0]  r_midpoint;
    logic [pcoc_pkg::WIN_W-1:0]  r_window;
    logic [SAMPLES_LOG2-1:0]     r_count, n_count;
    logic                        r_s1_valid;
    pcoc_pkg::t_stage_ctrl       r_s1_ctrl;

    logic                        accept;
    logic                        advance;
    pcoc_pkg::t_opcode           opcode;
    pcoc_pkg::t_lane_cmd         cmd;
    logic [ADC_BITS-1:0]         samples [pcoc_pkg::NUM_PHASES];
    logic signed [pcoc_pkg::CUR_W-1:0] currents [pcoc_pkg::NUM_PHASES];
    logic [pcoc_pkg::NUM_PHASES-1:0]   out_window;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= pcoc_pkg::GAIN_RESET;
            r_midpoint <= pcoc_pkg::MIDPOINT_RESET;
            r_window   <= pcoc_pkg::WINDOW_RESET;
        end else if (i_cfg.valid) begin
            case (pcoc_pkg::t_cfg_index'(i_cfg.index))
                pcoc_pkg::CFG_GAIN:     r_gain     <= i_cfg.data;
                pcoc_pkg::CFG_MIDPOINT: r_midpoint <= i_cfg.data[pcoc_pkg::MID_W-1:0];
                pcoc_pkg::CFG_WINDOW:   r_window   <= i_cfg.data[pcoc_pkg::WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_req.ready = !r_s1_valid || advance;
    assign accept      = i_req.valid && i_req.ready;
    assign opcode      = pcoc_pkg::t_opcode'(i_req.opcode);

    always_comb begin
        cmd      = '0;
        cmd.load = accept;
        cmd.acc  = accept && (opcode == pcoc_pkg::OPC_CAL);
        cmd.clr  = accept && (opcode == pcoc_pkg::OPC_RESTART);
        cmd.fin  = cmd.acc && (r_count == '1);
    end

    // The count wraps to zero on the sample that completes a run.
    always_comb begin
        n_count = r_count;
        if (cmd.clr) begin
            n_count = '0;
        end else if (cmd.acc) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctrl.conv <= (opcode == pcoc_pkg::OPC_CONVERT);
            r_s1_ctrl.done <= cmd.fin;
        end
    end

    assign samples[0] = i_req.sample_a;
    assign samples[1] = i_req.sample_b;
    assign samples[2] = i_req.sample_c;

    for (genvar p = 0; p < pcoc_pkg::NUM_PHASES; p++) begin : g_lane
        pcoc_lane #(
            .SAMPLES_LOG2 (SAMPLES_LOG2),
            .ADC_BITS     (ADC_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_sample     (samples[p]),
            .i_gain       (r_gain),
            .i_midpoint   (r_midpoint),
            .i_window     (r_window),
            .o_current    (currents[p]),
            .o_out_window (out_window[p])
        );
    end

    pcoc_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (r_s1_valid),
        .i_ctrl       (r_s1_ctrl),
        .i_current    (currents),
        .i_out_window (out_window),
        .o_advance    (advance),
        .o_rsp        (o_rsp)
    );

endmodule

FILE: dv/phase_current_offset_calibrate_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for phase_current_offset_calibrate_top: directed table, then
// randomized calibration runs and conversions, checked against an in-line predictor.
// Depends on pcoc_pkg, the three channel interfaces and the RTL under rtl/.
module phase_current_offset_calibrate_top_test;
    import pcoc_pkg::*;

    localparam int SAMPLE_W     = ADC_BITS_DEF;
    localparam int ADC_MAX      = (1 << ADC_BITS_DEF) - 1;
    localparam int CAL_LEN      = 1 << SAMPLES_LOG2_DEF;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_ITEMS   = 100;
    localparam int NUM_RUNS     = 4;
    localparam int SRC_IDLE [NUM_RUNS] = '{0, 30, 0, 20};
    localparam int SNK_IDLE [NUM_RUNS] = '{0, 0, 35, 20};

    typedef struct packed {
        logic signed [CUR_W-1:0] current_a;
        logic signed [CUR_W-1:0] current_b;
        logic signed [CUR_W-1:0] current_c;
        logic                    cal_done;
        logic                    cal_fault;
    } phase_result_t;

    typedef struct packed {
        bit                      is_cfg;
        t_opcode                 op;
        t_cfg_index              reg_sel;
        logic [CFG_DATA_W-1:0]   wdata;
        logic [SAMPLE_W-1:0]     a;
        logic [SAMPLE_W-1:0]     b;
        logic [SAMPLE_W-1:0]     c;
        bit                      typed;
        logic signed [CUR_W-1:0] want_a;
        logic signed [CUR_W-1:0] want_b;
        logic signed [CUR_W-1:0] want_c;
    } stim_row_t;

    // Typed rows rely on the reset offsets of midscale and a gain of 1.0, or of 0 after the write of 16'h0000.
    //  cfg  opcode       register      wdata     a     b     c  typed  want_a  want_b  want_c
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{0, OPC_CONVERT, CFG_GAIN,     0,        2048, 2048, 2048, 1, 0,     0,     0},
        '{0, OPC_CONVERT, CFG_GAIN,     0,        4095, 0,    2048, 1, 2047,  -2048, 0},
        '{0, OPC_CONVERT, CFG_GAIN,     0,        0,    4095, 1,    1, -2048, 2047,  -2047},
        '{0, OPC_RESTART, CFG_GAIN,     0,        4095, 4095, 4095, 1, 0,     0,     0},
        '{0, OPC_CAL,     CFG_GAIN,     0,        4095, 0,    4095, 1, 0,     0,     0},
        '{0, OPC_NONE,    CFG_GAIN,     0,        4095, 4095, 4095, 1, 0,     0,     0},
        '{0, OPC_CAL,     CFG_GAIN,     0,        0,    4095, 0,    1, 0,     0,     0},
        '{0, OPC_CONVERT, CFG_GAIN,     0,        2049, 2047, 4095, 1, 1,     -1,    2047},
        '{0, OPC_RESTART, CFG_GAIN,     0,        0,    0,    0,    1, 0,     0,     0},
        '{1, OPC_NONE,    CFG_GAIN,     16'hFFFF, 0,    0,    0,    0, 0,     0,     0},
        '{0, OPC_CONVERT, CFG_GAIN,     0,        4095, 0,    2048, 0, 0,     0,     0},
        '{0, OPC_CONVERT, CFG_GAIN,     0,        0,    4095, 2047, 0, 0,     0,     0},
        '{1, OPC_NONE,    CFG_GAIN,     16'h0000, 0,    0,    0,    0, 0,     0,     0},
        '{0, OPC_CONVERT, CFG_GAIN,     0,        4095, 0,    1234, 1, 0,     0,     0},
        '{1, OPC_NONE,    CFG_GAIN,     16'h0001, 0,    0,    0,    0, 0,     0,     0},
        '{0, OPC_CONVERT, CFG_GAIN,     0,        0,    4095, 2047, 0, 0,     0,     0},
        '{1, OPC_NONE,    CFG_GAIN,     16'h0180, 0,    0,    0,    0, 0,     0,     0},
        '{0, OPC_CONVERT, CFG_GAIN,     0,        2049, 2047, 2051, 0, 0,     0,     0},
        '{1, OPC_NONE,    CFG_UNUSED,   16'hFFFF, 0,    0,    0,    0, 0,     0,     0},
        '{0, OPC_CONVERT, CFG_GAIN,     0,        2047, 2049, 0,    0, 0,     0,     0},
        '{1, OPC_NONE,    CFG_MIDPOINT, 16'hF800, 0,    0,    0,    0, 0,     0,     0},
        '{1, OPC_NONE,    CFG_WINDOW,   16'hF04B, 0,    0,    0,    0, 0,     0,     0},
        '{1, OPC_NONE,    CFG_GAIN,     16'h0100, 0,    0,    0,    0, 0,     0,     0},
        '{0, OPC_CAL,     CFG_GAIN,     0,        1,    2,    3,    0, 0,     0,     0},
        '{0, OPC_RESTART, CFG_GAIN,     0,        4095, 0,    4095, 0, 0,     0,     0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pcoc_req_if req_ch ();
    pcoc_rsp_if rsp_ch ();
    pcoc_cfg_if cfg_ch ();

    phase_current_offset_calibrate_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: registers, accumulators and stored offsets.
    logic [GAIN_W-1:0]   gain_q   = GAIN_RESET;
    logic [MID_W-1:0]    mid_q    = MIDPOINT_RESET;
    logic [WIN_W-1:0]    win_q    = WINDOW_RESET;
    logic [21:0]         sum_a    = '0;
    logic [21:0]         sum_b    = '0;
    logic [21:0]         sum_c    = '0;
    logic [10:0]         cal_count = '0;
    logic [SAMPLE_W-1:0] ofs_a    = 12'd2048;
    logic [SAMPLE_W-1:0] ofs_b    = 12'd2048;
    logic [SAMPLE_W-1:0] ofs_c    = 12'd2048;
    bit                  calibration_finished;

    phase_result_t awaited_results [$];
    int          mismatch_count = 0;
    int unsigned src_idle_pct   = 15;
    int unsigned snk_idle_pct   = 15;

    function automatic int unsigned idle_cycles(int unsigned pct);
        if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic logic [SAMPLE_W-1:0] any_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return ADC_MAX;
        return SAMPLE_W'($urandom_range(0, ADC_MAX));
    endfunction

    function automatic logic [SAMPLE_W-1:0] noisy_sample(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > ADC_MAX) v = ADC_MAX;
        return SAMPLE_W'(v);
    endfunction

    // Offset-corrected reading times the Q8.8 gain, floor-divided by 256 and clamped to the 21-bit range.
    function automatic logic signed [CUR_W-1:0] scale_current(logic [SAMPLE_W-1:0] raw,
                                                             logic [SAMPLE_W-1:0] ofs);
        longint diff;
        longint q;
        diff = longint'(raw) - longint'(ofs);
        q = (diff * longint'(gain_q)) >>> 8;
        if (q > longint'(CUR_MAX)) q = longint'(CUR_MAX);
        if (q < longint'(CUR_MIN)) q = longint'(CUR_MIN);
        return q[CUR_W-1:0];
    endfunction

    // The window bounds may go past either end of the ADC range; no wrapping.
    function automatic bit outside_window(logic [SAMPLE_W-1:0] ofs);
        int o;
        int m;
        int w;
        o = int'(ofs);
        m = int'(mid_q);
        w = int'(win_q);
        return (o > m + w) || (o < m - w);
    endfunction

    function automatic void clear_sums();
        sum_a = '0;
        sum_b = '0;
        sum_c = '0;
        cal_count = '0;
    endfunction

    function automatic phase_result_t compute_phase_result(t_opcode op,
                                                          logic [SAMPLE_W-1:0] sa,
                                                          logic [SAMPLE_W-1:0] sb,
                                                          logic [SAMPLE_W-1:0] sc);
        phase_result_t r;
        r = '0;
        case (op)
            OPC_RESTART: begin
                clear_sums();
            end
            OPC_CAL: begin
                sum_a = sum_a + sa;
                sum_b = sum_b + sb;
                sum_c = sum_c + sc;
                cal_count = cal_count + 1'b1;
                if (cal_count >= CAL_LEN) begin
                    ofs_a = SAMPLE_W'(sum_a >> SAMPLES_LOG2_DEF);
                    ofs_b = SAMPLE_W'(sum_b >> SAMPLES_LOG2_DEF);
                    ofs_c = SAMPLE_W'(sum_c >> SAMPLES_LOG2_DEF);
                    clear_sums();
                    r.cal_done  = 1'b1;
                    r.cal_fault = outside_window(ofs_a) || outside_window(ofs_b) ||
                                  outside_window(ofs_c);
                    calibration_finished = 1'b1;
                end
            end
            OPC_CONVERT: begin
                r.current_a = scale_current(sa, ofs_a);
                r.current_b = scale_current(sb, ofs_b);
                r.current_c = scale_current(sc, ofs_c);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void compare_field(string name, logic signed [CUR_W-1:0] want,
                                          logic signed [CUR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result();
        phase_result_t want;
        if (awaited_results.size() == 0) begin
            $error("result with no request awaiting it: current_a %0d, cal_done %0b",
                   rsp_ch.current_a, rsp_ch.cal_done);
            mismatch_count++;
        end else begin
            want = awaited_results.pop_front();
            compare_field("current_a", want.current_a, rsp_ch.current_a);
            compare_field("current_b", want.current_b, rsp_ch.current_b);
            compare_field("current_c", want.current_c, rsp_ch.current_c);
            compare_field("cal_done", want.cal_done, rsp_ch.cal_done);
            compare_field("cal_fault", want.cal_fault, rsp_ch.cal_fault);
        end
    endfunction

    always @(posedge i_clk) begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_result();
    end

    // Leaves valid high after acceptance so that back-to-back requests need no extra step.
    task automatic send_request(t_opcode op, logic [SAMPLE_W-1:0] sa,
                                logic [SAMPLE_W-1:0] sb, logic [SAMPLE_W-1:0] sc,
                                bit typed = 1'b0, phase_result_t typed_want = '0);
        int unsigned gap;
        phase_result_t want;
        gap = idle_cycles(src_idle_pct);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= op;
        req_ch.sample_a <= sa;
        req_ch.sample_b <= sb;
        req_ch.sample_c <= sc;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        want = compute_phase_result(op, sa, sb, sc);
        awaited_results.push_back(typed ? typed_want : want);
    endtask

    task automatic write_register(t_cfg_index sel, logic [CFG_DATA_W-1:0] value,
                                  bit hold_valid);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= sel;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (sel)
            CFG_GAIN:     gain_q = value;
            CFG_MIDPOINT: mid_q = value[MID_W-1:0];
            CFG_WINDOW:   win_q = value[WIN_W-1:0];
            default: ;
        endcase
        if (!hold_valid) cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int unsigned hold;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            hold = idle_cycles(snk_idle_pct);
            if (hold == 0) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        stim_row_t           row;
        phase_result_t       typed_want;
        logic [GAIN_W-1:0]   gain;
        logic [MID_W-1:0]    mid;
        logic [WIN_W-1:0]    win;
        int                  run_center [3];
        int                  run_spread [3];
        int                  break_at;
        int                  cal_sent;
        int unsigned         pick;

        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.opcode   <= OPC_NONE;
        req_ch.sample_a <= '0;
        req_ch.sample_b <= '0;
        req_ch.sample_c <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_GAIN;
        cfg_ch.data     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            row = DIRECTED_ROWS[i];
            if (row.is_cfg) begin
                drain_results();
                write_register(row.reg_sel, row.wdata, 1'b0);
            end else begin
                typed_want = '{row.want_a, row.want_b, row.want_c, 1'b0, 1'b0};
                send_request(row.op, row.a, row.b, row.c, row.typed, typed_want);
            end
        end

        for (int run = 0; run < NUM_RUNS; run++) begin
            drain_results();
            src_idle_pct = SRC_IDLE[run];
            snk_idle_pct = SNK_IDLE[run];
            gain = GAIN_W'($urandom);
            case (run)
                0: begin
                    // Offsets close to midscale: the window check passes.
                    gain = GAIN_W'($urandom_range(128, 512));
                    mid  = 12'd2048;
                    win  = 12'd75;
                    for (int k = 0; k < 3; k++) begin
                        run_center[k] = 2048 - 30 + int'($urandom_range(0, 60));
                        run_spread[k] = int'($urandom_range(0, 40));
                    end
                end
                1: begin
                    // Window reaching below zero and up to full scale.
                    gain = '1;
                    mid  = '0;
                    win  = 12'd4095;
                    for (int k = 0; k < 3; k++) begin
                        run_center[k] = int'($urandom_range(0, ADC_MAX));
                        run_spread[k] = 2047;
                    end
                end
                2: begin
                    gain = '0;
                    mid  = 12'd4095;
                    win  = '0;
                    run_center = '{ADC_MAX, ADC_MAX, int'($urandom_range(0, ADC_MAX))};
                    run_spread = '{0, 0, 0};
                end
                default: begin
                    // Offsets exactly on the window edges, the third one possibly just past.
                    mid = MID_W'($urandom_range(200, 3800));
                    win = WIN_W'($urandom_range(0, 150));
                    run_center = '{int'(mid) + int'(win), int'(mid) - int'(win),
                                   int'(mid) + int'(win) + int'($urandom_range(0, 1))};
                    run_spread = '{0, 0, 0};
                end
            endcase
            write_register(CFG_GAIN, gain, 1'b1);
            write_register(CFG_MIDPOINT, {4'($urandom), mid}, 1'b1);
            write_register(CFG_WINDOW, {4'($urandom), win}, run == 3);
            if (run == 3) write_register(CFG_UNUSED, CFG_DATA_W'($urandom), 1'b0);

            // The third run keeps whatever partial sums the previous tail left behind.
            if (run != 2) send_request(OPC_RESTART, any_sample(), any_sample(), any_sample());

            break_at = (run % 2 == 1) ? int'($urandom_range(50, 900)) : -1;
            cal_sent = 0;
            calibration_finished = 1'b0;
            while (!calibration_finished) begin
                pick = $urandom_range(0, 99);
                if (cal_sent == break_at) begin
                    send_request(OPC_RESTART, any_sample(), any_sample(), any_sample());
                    break_at = -1;
                end else if (pick < 92) begin
                    send_request(OPC_CAL, noisy_sample(run_center[0], run_spread[0]),
                                 noisy_sample(run_center[1], run_spread[1]),
                                 noisy_sample(run_center[2], run_spread[2]));
                    cal_sent++;
                end else if (pick < 97) begin
                    send_request(OPC_CONVERT, any_sample(), any_sample(), any_sample());
                end else begin
                    send_request(OPC_NONE, any_sample(), any_sample(), any_sample());
                end
            end

            repeat (TAIL_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_request(OPC_CONVERT, any_sample(), any_sample(), any_sample());
                else if (pick < 80)
                    send_request(OPC_CAL, any_sample(), any_sample(), any_sample());
                else if (pick < 90)
                    send_request(OPC_NONE, any_sample(), any_sample(), any_sample());
                else
                    send_request(OPC_RESTART, any_sample(), any_sample(), any_sample());
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Far beyond the slowest legal run, even with every gap and stall at its longest.
    initial begin : watchdog
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: phase_current_offset_calibrate_top.f
rtl/pcoc_pkg.sv
rtl/pcoc_req_if.sv
rtl/pcoc_rsp_if.sv
rtl/pcoc_cfg_if.sv
rtl/pcoc_lane.sv
rtl/pcoc_merge.sv
rtl/phase_current_offset_calibrate_top.sv
dv/phase_current_offset_calibrate_top_test.sv
